@@ sv/bsa_pkg.sv @@
package bsa_pkg;

    localparam int IDX_W   = 11;
    localparam int ACT_W   = 2;
    localparam int ST_W    = 2;
    localparam int TDATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK = 2'd2;

    localparam logic [ST_W-1:0] ST_OK            = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL          = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [ST_W-1:0] ST_OUT_OF_RANGE  = 2'd3;

    localparam int DEF_MASK_BITS       = 64;
    localparam int DEF_WORDS_PER_BLOCK = 4;
    localparam int DEF_NUM_BLOCKS      = 8;

endpackage

@@ sv/bsa_zscan.sv @@
module bsa_zscan #(
    parameter int MASK_BITS = bsa_pkg::DEF_MASK_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MASK_BITS-1:0]         i_word,
    output logic                         o_done,
    output logic [$clog2(MASK_BITS)-1:0] o_bit
);

    localparam int CHUNK = 16;
    localparam int CH_W  = $clog2(CHUNK);
    localparam int STEPS = (MASK_BITS + CHUNK - 1) / CHUNK;
    localparam int PW    = STEPS * CHUNK;
    localparam int BIT_W = $clog2(MASK_BITS);

    // inverted word: a one marks a free bit, padding above the word reads as taken
    logic [PW-1:0]    r_inv;
    logic [BIT_W-1:0] r_base;
    logic             r_busy;
    logic [CHUNK-1:0] chunk;
    logic [CH_W-1:0]  pos;
    logic             hit;

    always_comb begin
        chunk = r_inv[CHUNK-1:0];
        hit   = |chunk;
        pos   = '0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            if (chunk[i]) begin
                pos = CH_W'(i);
            end
        end
    end

    assign o_done = r_busy && hit;
    assign o_bit  = BIT_W'(r_base + pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // advance one chunk per cycle until a free bit shows up
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_inv  <= PW'(~i_word);
            r_base <= '0;
        end else if (r_busy && !hit) begin
            r_inv  <= r_inv >> CHUNK;
            r_base <= BIT_W'(r_base + CHUNK);
        end
    end

endmodule

@@ sv/bitmap_slot_allocator.sv @@
// Steps from accept to registered result: allocate skips open blocks with no free word, reads
//   the first block with room word by word and searches the first non-full word for a zero,
//   else opens the next block or reports full; free/check divide, range test, read and test.
// One item at a time; the next beat can be taken in the cycle after the result is registered.
// Synchronous active-low reset clears the sequencer, open block count and output valid;
//   the bitmap and count memories are not swept: a block's words are written when it opens.
module bitmap_slot_allocator #(
    parameter int MASK_BITS       = bsa_pkg::DEF_MASK_BITS,
    parameter int WORDS_PER_BLOCK = bsa_pkg::DEF_WORDS_PER_BLOCK,
    parameter int NUM_BLOCKS      = bsa_pkg::DEF_NUM_BLOCKS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bsa_pkg::TDATA_W-1:0]  i_s_tdata,  // [10:0] slot_index
    input  logic [bsa_pkg::ACT_W-1:0]    i_s_tuser,  // [1:0] action
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bsa_pkg::TDATA_W-1:0]  o_m_tdata,  // [10:0] result_index
    output logic [bsa_pkg::ST_W-1:0]     o_m_tuser   // [1:0] status
);

    localparam int IDX_W  = bsa_pkg::IDX_W;
    localparam int WORDS  = NUM_BLOCKS * WORDS_PER_BLOCK;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BA_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BLK_W  = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W  = $clog2(WORDS_PER_BLOCK + 1);
    localparam int WSEL_W = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int BIT_W  = $clog2(MASK_BITS);
    localparam int SPB    = WORDS_PER_BLOCK * MASK_BITS;
    // block = idx / SPB by reciprocal, exact for every 11-bit idx
    localparam int SH_B   = IDX_W + $clog2(SPB);
    localparam int R_B    = ((1 << SH_B) + SPB - 1) / SPB;
    localparam int RB_W   = IDX_W + 2;
    localparam int P1_W   = IDX_W + RB_W;
    // word = within / MASK_BITS by reciprocal, exact for within < 2**WI_W
    localparam int WI_W   = $clog2(SPB);
    localparam int SH_W   = WI_W + $clog2(MASK_BITS);
    localparam int R_W    = ((1 << SH_W) + MASK_BITS - 1) / MASK_BITS;
    localparam int RW_W   = WI_W + 2;
    localparam int P2_W   = WI_W + RW_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ACNT, S_ATEST, S_WRD, S_WTEST, S_ZSCAN, S_OPEN,
        S_DIV1, S_DIV2, S_DIV3, S_DIV4, S_FRD, S_FTEST, S_RESP
    } t_state;

    t_state                    r_state;
    logic [bsa_pkg::ACT_W-1:0] r_act;
    logic [IDX_W-1:0]          r_idx;
    logic [BLK_W-1:0]          r_open;
    logic [BLK_W-1:0]          r_blk;
    logic [WSEL_W-1:0]         r_wsel;
    logic [WA_W-1:0]           r_word_addr;
    logic [BIT_W-1:0]          r_bit;
    logic [P1_W-1:0]           r_prod1;
    logic [P2_W-1:0]           r_prod2;
    logic [WI_W-1:0]           r_within;
    logic [IDX_W-1:0]          r_res_idx;
    logic [bsa_pkg::ST_W-1:0]  r_res_st;
    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_idx;
    logic [bsa_pkg::ST_W-1:0]  r_out_st;

    logic [MASK_BITS-1:0]      occ_mem [WORDS];
    logic [MASK_BITS-1:0]      r_occ_q;
    logic [CNT_W-1:0]          cnt_mem [NUM_BLOCKS];
    logic [CNT_W-1:0]          r_cnt_q;

    logic                      occ_we;
    logic [MASK_BITS-1:0]      occ_wd;
    logic                      cnt_we;
    logic [CNT_W-1:0]          cnt_wd;
    logic                      zs_start;
    logic                      zs_done;
    logic [BIT_W-1:0]          zs_bit;
    logic [MASK_BITS-1:0]      zs_mask;
    logic [MASK_BITS-1:0]      f_mask;
    logic [MASK_BITS-1:0]      alloc_word;
    logic [IDX_W-1:0]          qb;
    logic [WSEL_W-1:0]         wq;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = bsa_pkg::TDATA_W'(r_out_idx);
    assign o_m_tuser  = r_out_st;

    assign zs_mask    = MASK_BITS'(1) << zs_bit;
    assign f_mask     = MASK_BITS'(1) << r_bit;
    assign alloc_word = r_occ_q | zs_mask;
    assign qb         = IDX_W'(r_prod1 >> SH_B);
    assign wq         = WSEL_W'(r_prod2 >> SH_W);

    bsa_zscan #(
        .MASK_BITS(MASK_BITS)
    ) u_zscan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (zs_start),
        .i_word  (r_occ_q),
        .o_done  (zs_done),
        .o_bit   (zs_bit)
    );

    always_comb begin
        occ_we   = 1'b0;
        occ_wd   = '0;
        cnt_we   = 1'b0;
        cnt_wd   = '0;
        zs_start = 1'b0;
        case (r_state)
            S_OPEN: begin
                // slot 0 of the new block is taken at once
                occ_we = 1'b1;
                occ_wd = (r_wsel == '0) ? MASK_BITS'(1) : '0;
                cnt_we = (r_wsel == '0);
                cnt_wd = CNT_W'(WORDS_PER_BLOCK);
            end
            S_WTEST: begin
                zs_start = !(&r_occ_q);
            end
            S_ZSCAN: begin
                if (zs_done) begin
                    occ_we = 1'b1;
                    occ_wd = alloc_word;
                    cnt_we = &alloc_word;
                    cnt_wd = CNT_W'(r_cnt_q - 1'b1);
                end
            end
            S_FTEST: begin
                if (r_occ_q[r_bit] && r_act == bsa_pkg::ACT_FREE) begin
                    occ_we = 1'b1;
                    occ_wd = r_occ_q & ~f_mask;
                    cnt_we = &r_occ_q;
                    cnt_wd = CNT_W'(r_cnt_q + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[r_word_addr] <= occ_wd;
        end
        r_occ_q <= occ_mem[r_word_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[r_blk[BA_W-1:0]] <= cnt_wd;
        end
        r_cnt_q <= cnt_mem[r_blk[BA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the response step handles the output register itself
            if (r_out_valid && i_m_tready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act     <= i_s_tuser;
                        r_idx     <= i_s_tdata[IDX_W-1:0];
                        r_res_idx <= i_s_tdata[IDX_W-1:0];
                        r_blk     <= '0;
                        case (i_s_tuser)
                            bsa_pkg::ACT_ALLOC: begin
                                r_state <= S_ACNT;
                            end
                            bsa_pkg::ACT_FREE, bsa_pkg::ACT_CHECK: begin
                                r_state <= S_DIV1;
                            end
                            default: begin
                                r_res_st <= bsa_pkg::ST_OUT_OF_RANGE;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ACNT: begin
                    if (r_blk >= r_open) begin
                        if (r_open == BLK_W'(NUM_BLOCKS)) begin
                            r_res_idx <= '0;
                            r_res_st  <= bsa_pkg::ST_FULL;
                            r_state   <= S_RESP;
                        end else begin
                            r_wsel      <= '0;
                            r_word_addr <= WA_W'(r_blk * WORDS_PER_BLOCK);
                            r_state     <= S_OPEN;
                        end
                    end else begin
                        r_state <= S_ATEST;
                    end
                end
                S_ATEST: begin
                    // skip blocks with no free word
                    if (r_cnt_q == '0) begin
                        r_blk   <= BLK_W'(r_blk + 1'b1);
                        r_state <= S_ACNT;
                    end else begin
                        r_wsel      <= '0;
                        r_word_addr <= WA_W'(r_blk * WORDS_PER_BLOCK);
                        r_state     <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_state <= S_WTEST;
                end
                S_WTEST: begin
                    if (&r_occ_q) begin
                        r_wsel      <= WSEL_W'(r_wsel + 1'b1);
                        r_word_addr <= WA_W'(r_word_addr + 1'b1);
                        r_state     <= S_WRD;
                    end else begin
                        r_state <= S_ZSCAN;
                    end
                end
                S_ZSCAN: begin
                    if (zs_done) begin
                        r_res_idx <= IDX_W'(r_blk * SPB + r_wsel * MASK_BITS + zs_bit);
                        r_res_st  <= bsa_pkg::ST_OK;
                        r_state   <= S_RESP;
                    end
                end
                S_OPEN: begin
                    r_wsel      <= WSEL_W'(r_wsel + 1'b1);
                    r_word_addr <= WA_W'(r_word_addr + 1'b1);
                    if (r_wsel == WSEL_W'(WORDS_PER_BLOCK - 1)) begin
                        r_open    <= BLK_W'(r_open + 1'b1);
                        r_res_idx <= IDX_W'(r_blk * SPB);
                        r_res_st  <= bsa_pkg::ST_OK;
                        r_state   <= S_RESP;
                    end
                end
                S_DIV1: begin
                    r_prod1 <= P1_W'(r_idx * R_B);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (qb >= IDX_W'(r_open)) begin
                        r_res_st <= bsa_pkg::ST_OUT_OF_RANGE;
                        r_state  <= S_RESP;
                    end else begin
                        r_blk    <= BLK_W'(qb);
                        r_within <= WI_W'(r_idx - IDX_W'(qb * SPB));
                        r_state  <= S_DIV3;
                    end
                end
                S_DIV3: begin
                    r_prod2 <= P2_W'(r_within * R_W);
                    r_state <= S_DIV4;
                end
                S_DIV4: begin
                    r_bit       <= BIT_W'(r_within - WI_W'(wq * MASK_BITS));
                    r_word_addr <= WA_W'(r_blk * WORDS_PER_BLOCK + wq);
                    r_state     <= S_FRD;
                end
                S_FRD: begin
                    r_state <= S_FTEST;
                end
                S_FTEST: begin
                    r_res_st <= r_occ_q[r_bit] ? bsa_pkg::ST_OK : bsa_pkg::ST_NOT_ALLOCATED;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_res_idx;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= BLK_W'(NUM_BLOCKS))
        else $error("open block count beyond limit");

    a_full_all_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == bsa_pkg::ST_FULL)
            |-> (r_open == BLK_W'(NUM_BLOCKS) && o_m_tdata == '0))
        else $error("full reported while a block is still unopened");

    a_scan_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        zs_start |-> (r_state == S_WTEST && r_cnt_q != '0))
        else $error("zero search started in a block with no free word");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZSCAN && zs_done) |-> (r_cnt_q != '0 && r_blk < r_open))
        else $error("slot set in a full or unopened block");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_RESP))
        else $error("result beat raised outside the response step");

endmodule

@@ sim/bitmap_slot_allocator_test.sv @@
module bitmap_slot_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS     = bsa_pkg::DEF_MASK_BITS;
    localparam int WORDS_PER_BLK = bsa_pkg::DEF_WORDS_PER_BLOCK;
    localparam int BLOCKS        = bsa_pkg::DEF_NUM_BLOCKS;
    localparam int SLOTS_PER_BLK = WORD_BITS * WORDS_PER_BLK;
    localparam logic [bsa_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [bsa_pkg::IDX_W-1:0] slot;
        logic [bsa_pkg::ST_W-1:0]  status;
    } t_reply;

    logic                        clk;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [bsa_pkg::TDATA_W-1:0] s_tdata  = '0;    // [10:0] slot_index
    logic [bsa_pkg::ACT_W-1:0]   s_tuser  = bsa_pkg::ACT_ALLOC;  // [1:0] action
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [bsa_pkg::TDATA_W-1:0] m_tdata;          // [10:0] result_index
    logic [bsa_pkg::ST_W-1:0]    m_tuser;          // [1:0] status

    // allocator state as the block should hold it
    logic [WORD_BITS-1:0]      occ_map [BLOCKS*WORDS_PER_BLK] = '{default: '0};
    int                        free_words [BLOCKS] = '{default: WORDS_PER_BLK};
    int                        blocks_open = 0;
    logic [bsa_pkg::IDX_W-1:0] held_slots [$];
    t_reply                    replies_due [$];

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int          mismatches    = 0;
    int          requests_sent = 0;
    int          cycle_count   = 0;
    int          status_seen [4] = '{default: 0};

    bitmap_slot_allocator uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Apply one request to the tracked state and return the reply it owes.
    function automatic t_reply predict_request(input logic [bsa_pkg::ACT_W-1:0] act,
                                               input logic [bsa_pkg::IDX_W-1:0] idx);
        t_reply r;
        int     b, w, k, blk, word_i, pos;
        logic   hit;
        r.slot   = idx;
        r.status = bsa_pkg::ST_OK;
        hit      = 1'b0;
        case (act)
            bsa_pkg::ACT_ALLOC: begin
                for (b = 0; b < blocks_open && !hit; b++) begin
                    if (free_words[b] != 0) begin
                        for (w = 0; w < WORDS_PER_BLK && !hit; w++) begin
                            word_i = b * WORDS_PER_BLK + w;
                            if (!(&occ_map[word_i])) begin
                                pos = 0;
                                while (occ_map[word_i][pos]) pos++;
                                occ_map[word_i][pos] = 1'b1;
                                if (&occ_map[word_i]) free_words[b]--;
                                r.slot = bsa_pkg::IDX_W'(b * SLOTS_PER_BLK + w * WORD_BITS
                                                         + pos);
                                hit = 1'b1;
                            end
                        end
                    end
                end
                if (!hit) begin
                    if (blocks_open >= BLOCKS) begin
                        r.slot   = '0;
                        r.status = bsa_pkg::ST_FULL;
                    end else begin
                        // open the next block and hand out its first slot
                        occ_map[blocks_open * WORDS_PER_BLK][0] = 1'b1;
                        r.slot = bsa_pkg::IDX_W'(blocks_open * SLOTS_PER_BLK);
                        blocks_open++;
                    end
                end
                if (r.status == bsa_pkg::ST_OK) held_slots.push_back(r.slot);
            end
            bsa_pkg::ACT_FREE, bsa_pkg::ACT_CHECK: begin
                blk    = int'(idx) / SLOTS_PER_BLK;
                word_i = int'(idx) / WORD_BITS;
                pos    = int'(idx) % WORD_BITS;
                if (blk >= blocks_open) begin
                    r.status = bsa_pkg::ST_OUT_OF_RANGE;
                end else if (!occ_map[word_i][pos]) begin
                    r.status = bsa_pkg::ST_NOT_ALLOCATED;
                end else if (act == bsa_pkg::ACT_FREE) begin
                    if (&occ_map[word_i]) free_words[blk]++;
                    occ_map[word_i][pos] = 1'b0;
                    for (k = 0; k < held_slots.size(); k++)
                        if (held_slots[k] == idx) held_slots.delete(k);
                end
            end
            default: r.status = bsa_pkg::ST_OUT_OF_RANGE;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [bsa_pkg::ACT_W-1:0] act,
                                input logic [bsa_pkg::IDX_W-1:0] idx,
                                output t_reply due);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= bsa_pkg::TDATA_W'(idx);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        due = predict_request(act, idx);
        replies_due.push_back(due);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    // Check each reply beat against the oldest outstanding prediction.
    always @(posedge clk) begin : reply_checker
        t_reply want;
        if (rst_n && $isunknown(m_tvalid))
            report_mismatch("output valid is unknown");
        if (rst_n && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat slot=%0d status=%0d",
                                          m_tdata[bsa_pkg::IDX_W-1:0], m_tuser));
            end else begin
                want = replies_due.pop_front();
                status_seen[int'(want.status)]++;
                if (m_tdata[bsa_pkg::IDX_W-1:0] !== want.slot)
                    report_mismatch($sformatf("result_index %0d, want %0d",
                                              m_tdata[bsa_pkg::IDX_W-1:0], want.slot));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                              m_tuser, want.status, want.slot));
                if (m_tdata[bsa_pkg::TDATA_W-1:bsa_pkg::IDX_W] !== '0)
                    report_mismatch($sformatf("tdata padding %h not zero",
                                              m_tdata[bsa_pkg::TDATA_W-1:bsa_pkg::IDX_W]));
            end
        end
        m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    task automatic run_directed();
        t_reply r;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // nothing open yet: everything is out of range
        send_request(bsa_pkg::ACT_CHECK, 11'd0,    r);
        send_request(bsa_pkg::ACT_FREE,  11'd2047, r);
        send_request(ACT_RESERVED,       11'd2047, r);
        // first allocate opens block 0; the index field is ignored
        send_request(bsa_pkg::ACT_ALLOC, 11'd2047, r);
        send_request(bsa_pkg::ACT_ALLOC, 11'd0,    r);
        send_request(bsa_pkg::ACT_CHECK, 11'd1,    r);
        send_request(bsa_pkg::ACT_FREE,  11'd0,    r);
        send_request(bsa_pkg::ACT_CHECK, 11'd0,    r);
        send_request(bsa_pkg::ACT_FREE,  11'd0,    r);
        send_request(bsa_pkg::ACT_ALLOC, 11'h555,  r);
        send_request(bsa_pkg::ACT_CHECK, 11'd255,  r);
        send_request(bsa_pkg::ACT_CHECK, 11'd256,  r);
        send_request(bsa_pkg::ACT_FREE,  11'd1024, r);
        send_request(ACT_RESERVED,       11'd0,    r);
        send_request(bsa_pkg::ACT_FREE,  11'd1,    r);
        send_request(bsa_pkg::ACT_CHECK, 11'h2AA,  r);
        send_request(bsa_pkg::ACT_ALLOC, 11'h7FF,  r);
        wait_drained();
    endtask

    // Mostly allocates and frees/checks of held slots, with some noise.
    task automatic run_random(input int n);
        t_reply                    r;
        int                        pick, k;
        logic [bsa_pkg::IDX_W-1:0] bound_idx;
        repeat (n) begin
            pick = $urandom_range(99, 0);
            if (pick < 50 || (pick < 82 && held_slots.size() == 0)) begin
                send_request(bsa_pkg::ACT_ALLOC, bsa_pkg::IDX_W'($urandom), r);
            end else if (pick < 70) begin
                k = $urandom_range(held_slots.size() - 1, 0);
                send_request(bsa_pkg::ACT_FREE, held_slots[k], r);
            end else if (pick < 82) begin
                k = $urandom_range(held_slots.size() - 1, 0);
                send_request(bsa_pkg::ACT_CHECK, held_slots[k], r);
            end else if (pick < 90) begin
                send_request(pick[0] ? bsa_pkg::ACT_FREE : bsa_pkg::ACT_CHECK,
                             bsa_pkg::IDX_W'($urandom), r);
            end else if (pick < 95) begin
                // last open slot or first slot past the open range
                bound_idx = bsa_pkg::IDX_W'(blocks_open * SLOTS_PER_BLK - pick[1]);
                send_request(pick[0] ? bsa_pkg::ACT_FREE : bsa_pkg::ACT_CHECK, bound_idx, r);
            end else begin
                send_request(ACT_RESERVED, bsa_pkg::IDX_W'($urandom), r);
            end
        end
        wait_drained();
    endtask

    // Open every block, run into the full case, then punch holes and refill.
    task automatic run_fill_and_recover();
        t_reply r;
        int     k;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        r.status = bsa_pkg::ST_OK;
        while (r.status != bsa_pkg::ST_FULL)
            send_request(bsa_pkg::ACT_ALLOC, bsa_pkg::IDX_W'($urandom), r);
        send_request(bsa_pkg::ACT_ALLOC, '0,       r);
        send_request(bsa_pkg::ACT_CHECK, 11'd2047, r);
        send_request(bsa_pkg::ACT_FREE,  11'd2047, r);
        send_request(bsa_pkg::ACT_CHECK, 11'd2047, r);
        send_request(bsa_pkg::ACT_ALLOC, '0,       r);
        send_request(bsa_pkg::ACT_ALLOC, '0,       r);
        repeat (60) begin
            k = $urandom_range(held_slots.size() - 1, 0);
            send_request(bsa_pkg::ACT_FREE, held_slots[k], r);
        end
        repeat (20) begin
            k = $urandom_range(1, 0);
            send_request(k[0] ? bsa_pkg::ACT_FREE : bsa_pkg::ACT_CHECK,
                         bsa_pkg::IDX_W'($urandom), r);
        end
        sink_idle_pct = 50;
        repeat (70) send_request(bsa_pkg::ACT_ALLOC, bsa_pkg::IDX_W'($urandom), r);
        wait_drained();
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        src_idle_pct  = 9;
        sink_idle_pct = 85;
        run_random(270);
        src_idle_pct  = 85;
        sink_idle_pct = 9;
        run_random(270);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(260);
        run_fill_and_recover();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests checked: %0d ok, %0d full, %0d not allocated, %0d out of range",
                 requests_sent, status_seen[bsa_pkg::ST_OK], status_seen[bsa_pkg::ST_FULL],
                 status_seen[bsa_pkg::ST_NOT_ALLOCATED], status_seen[bsa_pkg::ST_OUT_OF_RANGE]);
        $display("%0d of %0d blocks opened, %0d slots held at the end, %0d mismatches",
                 blocks_open, BLOCKS, held_slots.size(), mismatches);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ bitmap_slot_allocator.f @@
sv/bsa_pkg.sv
sv/bsa_zscan.sv
sv/bitmap_slot_allocator.sv
sim/bitmap_slot_allocator_test.sv
